// ===== src/salct_pkg.sv =====
// ----------------------------------------------------------------------------
// salct_pkg
// Shared types, constants and helpers of the set-associative cache tag store.
// ----------------------------------------------------------------------------
package salct_pkg;

  localparam int MAX_SET_BITS = 8;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_W       = 32;
  localparam int TAG_W        = 32;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int SET_W        = MAX_SET_BITS;
  localparam int WAY_W        = $clog2(MAX_WAYS);
  localparam int RANK_W       = WAY_W;
  localparam int SB_W         = $clog2(MAX_SET_BITS + 1);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOOKUP    = 2'd0,
    OP_FILL      = 2'd1,
    OP_REMOVE    = 2'd2,
    OP_SET_DIRTY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT           = 3'd0,
    ST_HIT_DIRTY     = 3'd1,
    ST_MISS          = 3'd2,
    ST_SUCCESS       = 3'd3,
    ST_REPLACED      = 3'd4,
    ST_REMOVED_DIRTY = 3'd5,
    ST_NOT_FOUND     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    LS_INVALID = 2'd0,
    LS_CLEAN   = 2'd1,
    LS_DIRTY   = 2'd2
  } line_state_t;

  typedef enum logic {
    S_IDLE,
    S_PROC
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    line_state_t       lstate;
    logic [RANK_W-1:0] rank;
  } way_t;

  typedef way_t [MAX_WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] victim_address;
    logic              victim_dirty;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [TAG_W-1:0] tag;
    logic [SET_W-1:0] set;
  } req_t;

  function automatic row_t reset_row();
    row_t r;
    for (int w = 0; w < MAX_WAYS; w++) begin
      r[w].tag    = '0;
      r[w].lstate = LS_INVALID;
      r[w].rank   = RANK_W'(w);
    end
    return r;
  endfunction

endpackage

// ===== src/salct_ram.sv =====
// ----------------------------------------------------------------------------
// salct_ram
// Simple dual-port synchronous ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module salct_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/salct_update.sv =====
// ----------------------------------------------------------------------------
// salct_update
// Set row update: tag match, way choice, lru reorder and result of one item.
// ----------------------------------------------------------------------------
module salct_update (
  input  salct_pkg::req_t                  req,
  input  salct_pkg::row_t                  row,
  input  logic [salct_pkg::SB_W-1:0]       set_bits,
  input  logic [3:0]                       block_log2,
  input  logic [1:0]                       ways_log2,
  output salct_pkg::row_t                  row_next,
  output salct_pkg::out_item_t             result
);
  import salct_pkg::*;

  logic [WAY_W:0]      nways;
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] inv;
  logic                hit_any;
  logic                inv_any;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    inv_way;
  logic [WAY_W-1:0]    lru_way;
  logic [WAY_W-1:0]    tw;
  logic                recent;
  logic [RANK_W-1:0]   r;
  logic [ADDR_W-1:0]   vbase;

  assign nways = (WAY_W+1)'(1) << ways_log2;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (WAY_W+1)'(w) < nways;
      match[w]  = in_use[w] && (row[w].lstate != LS_INVALID) && (row[w].tag == req.tag);
      inv[w]    = in_use[w] && (row[w].lstate == LS_INVALID);
    end
  end

  // lowest matching and lowest free way
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (inv[w]) begin
        inv_way = WAY_W'(w);
      end
    end
  end

  assign hit_any = |match;
  assign inv_any = |inv;

  // oldest way, lowest on a tie
  always_comb begin
    lru_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (row[w].rank > row[lru_way].rank)) begin
        lru_way = WAY_W'(w);
      end
    end
  end

  assign vbase = (ADDR_W'(row[lru_way].tag) << set_bits) | ADDR_W'(req.set);

  always_comb begin
    row_next = row;
    result   = '{status: ST_HIT, victim_address: '0, victim_dirty: 1'b0};
    tw       = hit_way;
    recent   = 1'b0;
    unique case (req.op)
      OP_LOOKUP: begin
        if (hit_any) begin
          result.status = (row[hit_way].lstate == LS_DIRTY) ? ST_HIT_DIRTY : ST_HIT;
          recent = 1'b1;
        end else begin
          result.status = ST_MISS;
        end
      end
      OP_FILL: begin
        recent = 1'b1;
        if (hit_any) begin
          row_next[hit_way].lstate = LS_CLEAN;
          result.status = ST_SUCCESS;
        end else begin
          if (inv_any) begin
            tw = inv_way;
            result.status = ST_SUCCESS;
          end else begin
            tw = lru_way;
            result.status         = ST_REPLACED;
            result.victim_dirty   = (row[lru_way].lstate == LS_DIRTY);
            result.victim_address = vbase << block_log2;
          end
          row_next[tw].lstate = LS_CLEAN;
          row_next[tw].tag    = req.tag;
        end
      end
      OP_REMOVE: begin
        if (hit_any) begin
          recent = 1'b1;
          row_next[hit_way].lstate = LS_INVALID;
          if (row[hit_way].lstate == LS_DIRTY) begin
            result.status       = ST_REMOVED_DIRTY;
            result.victim_dirty = 1'b1;
          end else begin
            result.status = ST_SUCCESS;
          end
        end else begin
          result.status = ST_NOT_FOUND;
        end
      end
      OP_SET_DIRTY: begin
        if (hit_any) begin
          row_next[hit_way].lstate = LS_DIRTY;
          result.status = ST_SUCCESS;
        end else begin
          result.status = ST_NOT_FOUND;
        end
      end
      default: begin
        result.status = ST_NOT_FOUND;
      end
    endcase

    r = row[tw].rank;
    if (recent) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (in_use[w] && (row[w].rank < r)) begin
          row_next[w].rank = row[w].rank + RANK_W'(1);
        end
      end
      row_next[tw].rank = '0;
    end
  end

endmodule

// ===== src/set_assoc_lru_cache_tags_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_unit
// Tag, line state and lru store of a set-associative write-back cache.
// ----------------------------------------------------------------------------
// At the edge an item is accepted the read of its set row (tags, line states
// and lru ranks of all ways) is issued to the row ram; once the row has been
// read, the row is updated, written back and the result is loaded into the
// output register. No new item is taken while one is being updated. While a
// result waits in the output register one further item can be taken; it holds
// in the update state, and the input stalls, until the output register is free.
// The set row is read from the ram and then written back to it. A write to any
// configuration register empties the cache at once through one valid bit per
// set; no clearing pass is needed after reset.
module set_assoc_lru_cache_tags_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  salct_pkg::in_item_t                    in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output salct_pkg::out_item_t                   out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [salct_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [salct_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import salct_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [4:0]           size_log2;
  logic [3:0]           block_log2;
  logic [1:0]           ways_log2;
  logic [NUM_SETS-1:0]  row_valid;
  logic                 rvalid;
  req_t                 req;
  req_t                 req_next;
  logic                 accept;
  logic                 finish;
  logic                 cfg_write;

  logic [4:0]           used;
  logic [4:0]           diff;
  logic [SB_W-1:0]      sb;
  logic [4:0]           shamt;
  logic [SET_W:0]       set_mask;
  logic [ADDR_W-1:0]    set_full;

  row_t                 rd_row;
  row_t                 cur_row;
  row_t                 new_row;
  out_item_t            result;

  // geometry
  always_comb begin
    used = 5'(block_log2) + 5'(ways_log2);
    diff = size_log2 - used;
    if (size_log2 <= used) begin
      sb = '0;
    end else if (diff > 5'(MAX_SET_BITS)) begin
      sb = SB_W'(MAX_SET_BITS);
    end else begin
      sb = SB_W'(diff);
    end
    shamt    = 5'(block_log2) + 5'(sb);
    set_mask = ((SET_W+1)'(1) << sb) - (SET_W+1)'(1);
    set_full = in_data.address >> block_log2;
  end

  always_comb begin
    req_next.op  = in_data.op;
    req_next.tag = TAG_W'(in_data.address >> shamt);
    req_next.set = set_full[SET_W-1:0] & set_mask[SET_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_PROC;
        end
      end
      S_PROC: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    finish    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall  = rst;
        cfg_ready = !rst;
      end
      S_PROC: begin
        finish = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign accept    = in_valid && !in_stall;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers, a write empties every set
  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2  <= 5'd9;
      block_log2 <= 4'd4;
      ways_log2  <= 2'd1;
      row_valid  <= '0;
    end else begin
      if (finish) begin
        row_valid[req.set] <= 1'b1;
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_SIZE_LOG2: begin
            size_log2 <= cfg_data;
            row_valid <= '0;
          end
          CFG_BLOCK_LOG2: begin
            block_log2 <= cfg_data[3:0];
            row_valid  <= '0;
          end
          CFG_WAYS_LOG2: begin
            ways_log2 <= cfg_data[1:0];
            row_valid <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req    <= req_next;
      rvalid <= row_valid[req_next.set];
    end
  end

  salct_ram #(
    .ADDR_W (SET_W),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (req_next.set),
    .rd_data (rd_row),
    .wr_en   (finish),
    .wr_addr (req.set),
    .wr_data (new_row)
  );

  assign cur_row = rvalid ? rd_row : reset_row();

  salct_update u_update (
    .req        (req),
    .row        (cur_row),
    .set_bits   (sb),
    .block_log2 (block_log2),
    .ways_log2  (ways_log2),
    .row_next   (new_row),
    .result     (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= result;
    end
  end

endmodule
